/* rtl/core/ffha_pkg.sv */
`timescale 1ns / 1ps

package ffha_pkg;

  // Field widths of the request and response beats.
  localparam int KIND_W   = 1;
  localparam int REQ_W    = 12;
  localparam int ADDR_W   = 12;
  localparam int STATUS_W = 2;

  // Block headers carry a 15-bit size; sums of a position and a size fit 16 bits.
  localparam int SIZE_W = 15;
  localparam int SUM_W  = 16;
  localparam int BYTE_W = 8;

  localparam int POOL_BYTES_DEF = 4096;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_SPLIT,
    S_FREE_HDR,
    S_FREE_NXT,
    S_RESP
  } state_t;

endpackage

/* rtl/core/ffha_ram.sv */
`timescale 1ns / 1ps

module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/first_fit_heap_allocator_core.sv */
`timescale 1ns / 1ps

// Channel   Handshake              Beat contents
// request   req_valid/req_ready    kind, request_size, free_address
// response  rsp_valid/rsp_ready    address, status
//
// After reset a clearing pass writes one byte pair per cycle, (POOL_BYTES+1)/2
// pairs in all (2048 at the default size), with req_ready low. An allocate beat
// walks the block headers from position 0 and stops at the first fit; one more
// header write follows when a remainder is split off. A free beat reads its own
// header, then the next if it fits; none if the address is out of range. A finished
// response waits in the output register; the next one holds until rsp_ready frees it.

module first_fit_heap_allocator_core #(
  parameter int POOL_BYTES = ffha_pkg::POOL_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [ffha_pkg::KIND_W-1:0]   kind,
  input  logic [ffha_pkg::REQ_W-1:0]    request_size,
  input  logic [ffha_pkg::ADDR_W-1:0]   free_address,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [ffha_pkg::ADDR_W-1:0]   address,
  output logic [ffha_pkg::STATUS_W-1:0] status
);

  import ffha_pkg::*;

  // Byte positions in the pool. The pool is held in two banks, even bytes and
  // odd bytes, so the two header bytes at any position are read or written in
  // the same cycle no matter whether the header starts on an even or odd byte.
  localparam int AW         = $clog2(POOL_BYTES);
  localparam int BANK_DEPTH = (POOL_BYTES + 1) / 2;
  localparam int BAW        = $clog2(BANK_DEPTH);

  localparam logic [SUM_W-1:0]  POOL_S    = SUM_W'(POOL_BYTES);
  localparam logic [SIZE_W-1:0] POOL_SIZE = SIZE_W'(POOL_BYTES);
  localparam logic [BAW-1:0]    BANK_LAST = BAW'(BANK_DEPTH - 1);
  localparam logic [SUM_W-1:0]  TWO_S     = SUM_W'(2);

  state_t state, state_next;

  logic [BAW-1:0]    clr_idx;
  logic [AW-1:0]     pos;        // byte position whose header is being read
  logic [AW-1:0]     hdr;        // header being released by a free request
  logic [REQ_W-1:0]  want;
  logic [SIZE_W-1:0] fsize;      // size of the block being released
  logic [AW-1:0]     split_pos;
  logic [SIZE_W-1:0] split_size;
  logic [ADDR_W-1:0]   res_addr;
  logic [STATUS_W-1:0] res_status;

  // Memory port signals.
  logic              rd_en;
  logic [AW-1:0]     rd_byte;
  logic [AW:0]       rd_byte_p1;
  logic [BAW-1:0]    even_raddr, odd_raddr;
  logic [BYTE_W-1:0] even_q, odd_q;

  logic              wr_en;
  logic [AW-1:0]     wr_byte;
  logic [AW:0]       wr_byte_p1;
  logic [SIZE_W-1:0] wr_size;
  logic              wr_busy;
  logic [BYTE_W-1:0] wr_hi, wr_lo;
  logic              even_we, odd_we;
  logic [BAW-1:0]    even_waddr, odd_waddr;
  logic [BYTE_W-1:0] even_wd, odd_wd;

  // Header decode of the data returned for pos.
  logic [BYTE_W-1:0] rd_hi, rd_lo;
  logic [SIZE_W-1:0] cur_size;
  logic              cur_busy;
  logic [SUM_W-1:0]  pos_x, size_x, end_x, need_x;
  logic              hdr_out, chain_bad, fits, small_rest, at_end;
  logic              walk_fail, walk_fit, walk_on;

  logic [SUM_W-1:0]  fa_x;
  logic              fa_bad;
  logic              nx_ok;
  logic              accept;

  logic                res_load;
  logic [ADDR_W-1:0]   res_addr_next;
  logic [STATUS_W-1:0] res_status_next;
  logic                split_load;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  // Header byte at h lands in the odd bank when h is odd; the byte after it then
  // sits in the even bank one word up. Hence even index (h+1)/2, odd index h/2.
  assign rd_byte_p1 = {1'b0, rd_byte} + {{AW{1'b0}}, 1'b1};
  assign wr_byte_p1 = {1'b0, wr_byte} + {{AW{1'b0}}, 1'b1};
  assign even_raddr = BAW'(rd_byte_p1 >> 1);
  assign odd_raddr  = BAW'(rd_byte >> 1);

  assign rd_hi    = pos[0] ? odd_q : even_q;
  assign rd_lo    = pos[0] ? even_q : odd_q;
  assign cur_size = {rd_hi, rd_lo[BYTE_W-1:1]};
  assign cur_busy = rd_lo[0];

  assign pos_x  = SUM_W'(pos);
  assign size_x = SUM_W'(cur_size);
  assign end_x  = pos_x + size_x;
  assign need_x = SUM_W'(want) + TWO_S;

  // Walk decisions, in the order the chain rules apply: a header that does not
  // fit in the pool, then a broken size, then a fit, then the end of the pool.
  assign hdr_out    = (pos_x >= POOL_S - SUM_W'(1));
  assign chain_bad  = (cur_size < SIZE_W'(2)) || (end_x > POOL_S);
  assign fits       = !cur_busy && (size_x >= need_x);
  assign small_rest = (size_x < need_x + TWO_S);
  assign at_end     = (end_x >= POOL_S);
  assign walk_fail  = hdr_out || chain_bad || (!fits && at_end);
  assign walk_fit   = !hdr_out && !chain_bad && fits;
  assign walk_on    = !hdr_out && !chain_bad && !fits && !at_end;

  assign fa_x   = SUM_W'(free_address);
  assign fa_bad = (fa_x < TWO_S) || (fa_x >= POOL_S);

  // The block after the released one is looked at only when its header fits.
  assign nx_ok = (end_x < POOL_S - SUM_W'(1));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == BANK_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_ALLOC) begin
            state_next = S_WALK;
          end else if (fa_bad) begin
            state_next = S_RESP;
          end else begin
            state_next = S_FREE_HDR;
          end
        end
      end
      S_WALK: begin
        if (walk_fail || (walk_fit && small_rest)) begin
          state_next = S_RESP;
        end else if (walk_fit) begin
          state_next = S_SPLIT;
        end
      end
      S_SPLIT: state_next = S_RESP;
      S_FREE_HDR: begin
        state_next = nx_ok ? S_FREE_NXT : S_RESP;
      end
      S_FREE_NXT: state_next = S_RESP;
      S_RESP: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Memory accesses and result capture.
  always_comb begin
    rd_en           = 1'b0;
    rd_byte         = pos;
    wr_en           = 1'b0;
    wr_byte         = pos;
    wr_size         = cur_size;
    wr_busy         = 1'b0;
    res_load        = 1'b0;
    res_addr_next   = '0;
    res_status_next = ST_DONE;
    split_load      = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_ALLOC) begin
            rd_en   = 1'b1;
            rd_byte = '0;
          end else if (fa_bad) begin
            res_load        = 1'b1;
            res_status_next = ST_BAD_ADDR;
          end else begin
            rd_en   = 1'b1;
            rd_byte = AW'(fa_x - TWO_S);
          end
        end
      end
      S_WALK: begin
        if (walk_fail) begin
          res_load        = 1'b1;
          res_status_next = ST_NO_SPACE;
        end else if (walk_fit) begin
          wr_en         = 1'b1;
          wr_byte       = pos;
          wr_size       = small_rest ? cur_size : SIZE_W'(need_x);
          wr_busy       = 1'b1;
          split_load    = !small_rest;
          res_load      = 1'b1;
          res_addr_next = ADDR_W'(pos_x + TWO_S);
        end else if (walk_on) begin
          rd_en   = 1'b1;
          rd_byte = AW'(end_x);
        end
      end
      S_SPLIT: begin
        wr_en   = 1'b1;
        wr_byte = split_pos;
        wr_size = split_size;
      end
      S_FREE_HDR: begin
        if (nx_ok) begin
          rd_en   = 1'b1;
          rd_byte = AW'(end_x);
        end else begin
          wr_en    = 1'b1;
          wr_byte  = hdr;
          wr_size  = cur_size;
          res_load = 1'b1;
        end
      end
      S_FREE_NXT: begin
        wr_en    = 1'b1;
        wr_byte  = hdr;
        wr_size  = cur_busy ? fsize : fsize + cur_size;
        res_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Bank write ports. The clearing pass writes zeros, except the first word,
  // which takes the header of one free block that spans the whole pool.
  assign wr_hi = wr_size[SIZE_W-1:SIZE_W-BYTE_W];
  assign wr_lo = {wr_size[SIZE_W-BYTE_W-1:0], wr_busy};

  always_comb begin
    if (state == S_CLEAR) begin
      even_we    = 1'b1;
      odd_we     = 1'b1;
      even_waddr = clr_idx;
      odd_waddr  = clr_idx;
      even_wd    = '0;
      odd_wd     = '0;
      if (clr_idx == '0) begin
        even_wd = POOL_SIZE[SIZE_W-1:SIZE_W-BYTE_W];
        odd_wd  = {POOL_SIZE[SIZE_W-BYTE_W-1:0], 1'b0};
      end
    end else begin
      even_we    = wr_en;
      odd_we     = wr_en;
      even_waddr = BAW'(wr_byte_p1 >> 1);
      odd_waddr  = BAW'(wr_byte >> 1);
      even_wd    = wr_byte[0] ? wr_lo : wr_hi;
      odd_wd     = wr_byte[0] ? wr_hi : wr_lo;
    end
  end

  ffha_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(BANK_DEPTH)
  ) u_even (
    .clk  (clk),
    .we   (even_we),
    .waddr(even_waddr),
    .wdata(even_wd),
    .raddr(even_raddr),
    .rdata(even_q)
  );

  ffha_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(BANK_DEPTH)
  ) u_odd (
    .clk  (clk),
    .we   (odd_we),
    .waddr(odd_waddr),
    .wdata(odd_wd),
    .raddr(odd_raddr),
    .rdata(odd_q)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + BAW'(1);
      end
      if (state == S_RESP && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      pos <= rd_byte;
    end
    if (accept) begin
      want <= request_size;
      hdr  <= AW'(fa_x - TWO_S);
    end
    if (state == S_FREE_HDR) begin
      fsize <= cur_size;
    end
    if (split_load) begin
      split_pos  <= AW'(pos_x + need_x);
      split_size <= SIZE_W'(size_x - need_x);
    end
    if (res_load) begin
      res_addr   <= res_addr_next;
      res_status <= res_status_next;
    end
    if (state == S_RESP && (!rsp_valid || rsp_ready)) begin
      address <= res_addr;
      status  <= res_status;
    end
  end

endmodule
